@@ design/pending_interrupt_injector_macros.svh @@
// Assertion helpers for the RTL files; pie_state includes them.
`ifndef PENDING_INTERRUPT_INJECTOR_MACROS_SVH
`define PENDING_INTERRUPT_INJECTOR_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define PIE_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define PIE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/pie_pkg.sv @@
package pie_pkg;

  localparam int WORD_COUNT = 8;
  localparam int VEC_COUNT  = WORD_COUNT * 32;
  localparam int VEC_IDX_W  = (VEC_COUNT > 1) ? $clog2(VEC_COUNT) : 1;
  localparam int COUNT_W    = 9;
  localparam int ENC_SIZE   = 256;
  localparam int ENC_LEVELS = 8;

  localparam logic [1:0] REQ_RAISE    = 2'd0;
  localparam logic [1:0] REQ_REINJECT = 2'd1;
  localparam logic [1:0] REQ_ATTEMPT  = 2'd2;

  localparam logic [31:0] EVENT_VALID = 32'h8000_0000;
  localparam int INFO_VALID_POS = 31;
  localparam int INFO_TYPE_HI   = 10;
  localparam int INFO_TYPE_LO   = 8;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  vector;
    logic [31:0] exit_info;
    logic        if_flag;
    logic        shadow;
    logic        event_busy;
    logic        already_injected;
    logic        want_window;
  } req_t;

  typedef struct packed {
    logic               inject;
    logic [31:0]        event_word;
    logic               window_enable;
    logic               pending_valid;
    logic [7:0]         highest_pending;
    logic               was_pending;
    logic [COUNT_W-1:0] pending_total;
  } result_t;

endpackage

@@ design/pending_interrupt_injector.sv @@
// Channel | Handshake           | Payload
// in      | in_valid / in_ready | req_type vector exit_info if_flag shadow event_busy
//         |                     | already_injected want_window
// out     | out_valid/out_ready | inject event_word window_enable pending_valid
//         |                     | highest_pending was_pending pending_total
//
// An item waits in the input register, then its result lands in the output
// register; one item per cycle is sustained while the output is not stalled,
// set by the single bitmap update plus one 256-bit priority encode between them.
// Reset (rst, synchronous) empties the bitmap and count and both registers.
// A stalled output holds its result; the input register still fills behind it.
module pending_interrupt_injector
  import pie_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  vector,
  input  logic [31:0] exit_info,
  input  logic        if_flag,
  input  logic        shadow,
  input  logic        event_busy,
  input  logic        already_injected,
  input  logic        want_window,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        inject,
  output logic [31:0] event_word,
  output logic        window_enable,
  output logic        pending_valid,
  output logic [7:0]  highest_pending,
  output logic        was_pending,
  output logic [COUNT_W-1:0] pending_total
);

  logic    req_vld;
  req_t    req;
  logic    fire;
  result_t step_res;
  result_t res;

  // Advance the held item when the output register is empty or draining.
  assign fire     = req_vld && (!out_valid || out_ready);
  assign in_ready = !req_vld || fire;

  // Input register: hold the accepted item until it can be worked.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else if (in_ready) begin
      req_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req.req_type         <= req_type;
      req.vector           <= vector;
      req.exit_info        <= exit_info;
      req.if_flag          <= if_flag;
      req.shadow           <= shadow;
      req.event_busy       <= event_busy;
      req.already_injected <= already_injected;
      req.want_window      <= want_window;
    end
  end

  // Bitmap, count and cached highest vector; updated on fire.
  pie_state u_state (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .req    (req),
    .result (step_res)
  );

  // Output register: capture the result, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= step_res;
    end
  end

  assign inject          = res.inject;
  assign event_word      = res.event_word;
  assign window_enable   = res.window_enable;
  assign pending_valid   = res.pending_valid;
  assign highest_pending = res.highest_pending;
  assign was_pending     = res.was_pending;
  assign pending_total   = res.pending_total;

endmodule

@@ design/pie_prio_enc.sv @@
module pie_prio_enc
  import pie_pkg::*;
(
  input  logic [VEC_COUNT-1:0] bits,
  output logic                 found,
  output logic [7:0]           index
);

  logic [ENC_SIZE-1:0] padded;
  logic                node_vld [ENC_SIZE];
  logic [7:0]          node_idx [ENC_SIZE];

  generate
    if (VEC_COUNT < ENC_SIZE) begin : g_pad
      assign padded = {{(ENC_SIZE - VEC_COUNT){1'b0}}, bits};
    end else begin : g_full
      assign padded = bits;
    end
  endgenerate

  // Pairwise reduction tree: the upper half of each pair wins.
  always_comb begin
    for (int i = 0; i < ENC_SIZE; i++) begin
      node_vld[i] = padded[i];
      node_idx[i] = 8'(i);
    end
    for (int l = 0; l < ENC_LEVELS; l++) begin
      for (int i = 0; i < ENC_SIZE / 2; i++) begin
        if (i < (ENC_SIZE >> (l + 1))) begin
          node_idx[i] = node_vld[2*i+1] ? node_idx[2*i+1] : node_idx[2*i];
          node_vld[i] = node_vld[2*i] | node_vld[2*i+1];
        end
      end
    end
    found = node_vld[0];
    index = node_idx[0];
  end

endmodule

@@ design/pie_state.sv @@
module pie_state
  import pie_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  req_t    req,
  output result_t result
);

  `include "pending_interrupt_injector_macros.svh"

  logic [VEC_COUNT-1:0] pending;
  logic [VEC_COUNT-1:0] pending_next;
  logic [VEC_COUNT-1:0] masked;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   count_next;
  logic                 hp_vld;
  logic                 hp_vld_next;
  logic [7:0]           hp;
  logic [7:0]           hp_next;

  logic       enc_found;
  logic [7:0] enc_index;

  logic       raise_en;
  logic [7:0] raise_vec;
  logic       in_range;
  logic       dup;
  logic       do_set;
  logic       do_inject;

  // Bitmap with the current highest vector knocked out: its top bit is the
  // runner-up that takes over after an injection.
  always_comb begin
    for (int i = 0; i < VEC_COUNT; i++) begin
      masked[i] = pending[i] & ~(hp_vld && (hp[VEC_IDX_W-1:0] == VEC_IDX_W'(i)));
    end
  end

  pie_prio_enc u_enc (
    .bits  (masked),
    .found (enc_found),
    .index (enc_index)
  );

  always_comb begin
    raise_vec = (req.req_type == REQ_RAISE) ? req.vector : req.exit_info[7:0];
    raise_en  = (req.req_type == REQ_RAISE) ||
                ((req.req_type == REQ_REINJECT) && req.exit_info[INFO_VALID_POS] &&
                 (req.exit_info[INFO_TYPE_HI:INFO_TYPE_LO] == 3'd0));
    in_range  = ({1'b0, raise_vec[7:5]} < 4'(WORD_COUNT));
    dup       = raise_en && in_range && pending[raise_vec[VEC_IDX_W-1:0]];
    do_set    = raise_en && in_range && !pending[raise_vec[VEC_IDX_W-1:0]];
    do_inject = (req.req_type == REQ_ATTEMPT) && hp_vld && !req.already_injected &&
                req.if_flag && !req.shadow && !req.event_busy;

    pending_next = pending;
    count_next   = count;
    hp_vld_next  = hp_vld;
    hp_next      = hp;
    if (do_set) begin
      pending_next[raise_vec[VEC_IDX_W-1:0]] = 1'b1;
      count_next  = count + COUNT_W'(1);
      hp_vld_next = 1'b1;
      if (!hp_vld || (raise_vec > hp)) begin
        hp_next = raise_vec;
      end
    end else if (do_inject) begin
      pending_next = masked;
      if (count != '0) begin
        count_next = count - COUNT_W'(1);
      end
      hp_vld_next = enc_found;
      hp_next     = enc_found ? enc_index : 8'd0;
    end

    result.inject          = do_inject;
    result.event_word      = do_inject ? (EVENT_VALID | {24'd0, hp}) : 32'd0;
    result.window_enable   = (req.req_type == REQ_ATTEMPT) && (hp_vld_next || req.want_window);
    result.pending_valid   = hp_vld_next;
    result.highest_pending = hp_vld_next ? hp_next : 8'd0;
    result.was_pending     = dup;
    result.pending_total   = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      count   <= '0;
      hp_vld  <= 1'b0;
      hp      <= 8'd0;
    end else if (fire) begin
      pending <= pending_next;
      count   <= count_next;
      hp_vld  <= hp_vld_next;
      hp      <= hp_next;
    end
  end

  `PIE_ASSERT_IMPLY(a_hp_tracks_count, 1'b1, hp_vld == (count != '0), "highest flag disagrees with count")
  `PIE_ASSERT_IMPLY(a_hp_bit_set, hp_vld, pending[hp[VEC_IDX_W-1:0]], "cached highest vector not pending")
  `PIE_ASSERT_NEXT(a_inject_drops_count, fire && do_inject, count == $past(count) - COUNT_W'(1), "injection did not drop count")
  `PIE_ASSERT_IMPLY(a_count_bound, 1'b1, count <= COUNT_W'(VEC_COUNT), "pending count out of range")

endmodule

@@ verif/pending_interrupt_injector_tb.sv @@
`timescale 1ns / 1ps

module pending_interrupt_injector_tb;
  import pie_pkg::*;

  // Request code that the block must treat as a no-op.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  req_type = REQ_RAISE;
  logic [7:0]  vector = '0;
  logic [31:0] exit_info = '0;
  logic        if_flag = 1'b0;
  logic        shadow = 1'b0;
  logic        event_busy = 1'b0;
  logic        already_injected = 1'b0;
  logic        want_window = 1'b0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        inject;
  logic [31:0] event_word;
  logic        window_enable;
  logic        pending_valid;
  logic [7:0]  highest_pending;
  logic        was_pending;
  logic [COUNT_W-1:0] pending_total;

  pending_interrupt_injector DUT (.*);

  // 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the pending bitmap and its population count.
  logic [255:0]       pend_map = '0;
  logic [COUNT_W-1:0] pend_cnt = '0;

  req_t    req_q[$];     // requests waiting to be driven
  result_t status_q[$];  // predicted status, oldest first
  req_t    cur_req;
  result_t model_res;
  result_t exp_status;

  int fail_count   = 0;
  int accepted_cnt = 0;
  int total_items  = 0;
  int burst_left   = 1;
  int gap_left     = 0;

  logic [15:0] ready_pat   = 16'hffff;
  logic [3:0]  ready_pos   = '0;
  int          pat_rounds  = 0;

  // Return {found, vector} for the highest set bit of the map.
  function automatic logic [8:0] highest(input logic [255:0] m);
    logic [8:0] r;
    r = '0;
    for (int i = 0; i < 256; i++) begin
      if (m[i]) r = {1'b1, 8'(i)};
    end
    return r;
  endfunction

  // Set one vector; flag it when already pending.
  task automatic raise_vec(input logic [7:0] v, output logic dup);
    dup = 1'b0;
    if (pend_map[v]) begin
      dup = 1'b1;
    end else begin
      pend_map[v] = 1'b1;
      if (pend_cnt < 9'd256) pend_cnt = pend_cnt + 9'd1;
    end
  endtask

  // Advance the shadow state by one request and produce its status.
  task automatic apply_request(input req_t rq, output result_t rs);
    logic [8:0] top;
    logic       dup;
    rs  = '0;
    dup = 1'b0;
    case (rq.req_type)
      REQ_RAISE: begin
        raise_vec(rq.vector, dup);
      end
      REQ_REINJECT: begin
        // Only a valid external-interrupt info word re-raises its vector.
        if (rq.exit_info[INFO_VALID_POS] &&
            rq.exit_info[INFO_TYPE_HI:INFO_TYPE_LO] == 3'd0) begin
          raise_vec(rq.exit_info[7:0], dup);
        end
      end
      REQ_ATTEMPT: begin
        top = highest(pend_map);
        if (top[8] && !rq.already_injected && rq.if_flag && !rq.shadow &&
            !rq.event_busy) begin
          rs.inject     = 1'b1;
          rs.event_word = EVENT_VALID | {24'h0, top[7:0]};
          pend_map[top[7:0]] = 1'b0;
          if (pend_cnt > 0) pend_cnt = pend_cnt - 9'd1;
        end
        // Window opens when something is left or the caller asks for it.
        top = highest(pend_map);
        rs.window_enable = top[8] | rq.want_window;
      end
      default: begin
      end
    endcase
    top = highest(pend_map);
    rs.pending_valid   = top[8];
    rs.highest_pending = top[8] ? top[7:0] : 8'h00;
    rs.was_pending     = dup;
    rs.pending_total   = pend_cnt;
  endtask

  function automatic req_t mk(input logic [1:0] t, input logic [7:0] v,
                              input logic [31:0] info, input logic ifl,
                              input logic sh, input logic busy,
                              input logic done, input logic want);
    req_t rq;
    rq.req_type         = t;
    rq.vector           = v;
    rq.exit_info        = info;
    rq.if_flag          = ifl;
    rq.shadow           = sh;
    rq.event_busy       = busy;
    rq.already_injected = done;
    rq.want_window      = want;
    return rq;
  endfunction

  // Queue one random request; percentages pick raise, re-inject, attempt,
  // and whatever is left goes to the unused code.
  task automatic push_random(input int raise_pct, input int reinj_pct, input int att_pct);
    int          r;
    int          s;
    logic [31:0] a;
    logic [31:0] b;
    req_t        rq;
    r = $urandom_range(0, 99);
    s = $urandom_range(0, 99);
    a = $urandom;
    b = $urandom;
    // Start from full noise so every unused field toggles too.
    rq = mk(REQ_RAISE, a[7:0], b, a[8], a[9], a[10], a[11], a[12]);
    if (r < raise_pct) begin
      rq.req_type = REQ_RAISE;
    end else if (r < raise_pct + reinj_pct) begin
      rq.req_type = REQ_REINJECT;
      if (s < 85) begin
        rq.exit_info = {1'b1, b[30:11], 3'b000, a[7:0]};
      end else if (s < 93) begin
        rq.exit_info = {1'b0, b[30:0]};
      end else begin
        // Valid bit set, but a nonzero event type.
        rq.exit_info = {1'b1, b[30:11], (b[10:8] == 3'd0) ? 3'd3 : b[10:8], a[7:0]};
      end
    end else if (r < raise_pct + reinj_pct + att_pct) begin
      rq.req_type = REQ_ATTEMPT;
      if (s < 75) begin
        // Guest can take an interrupt.
        rq.if_flag          = 1'b1;
        rq.shadow           = 1'b0;
        rq.event_busy       = 1'b0;
        rq.already_injected = 1'b0;
      end
    end else begin
      rq.req_type = REQ_UNUSED;
    end
    req_q.push_back(rq);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
      fail_count++;
    end
  endtask

  // Driver: hold the item until accepted, then advance or idle for a gap.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        apply_request(cur_req, model_res);
        status_q.push_back(model_res);
        accepted_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          req_type         <= cur_req.req_type;
          vector           <= cur_req.vector;
          exit_info        <= cur_req.exit_info;
          if_flag          <= cur_req.if_flag;
          shadow           <= cur_req.shadow;
          event_busy       <= cur_req.event_busy;
          already_injected <= cur_req.already_injected;
          want_window      <= cur_req.want_window;
          in_valid         <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // New burst; a quarter of them follow with no gap at all.
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest prediction, and
  // drive ready from a 16-bit pattern that is swapped every four rounds.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        $error("result arrived with no request outstanding");
        fail_count++;
      end else begin
        exp_status = status_q.pop_front();
        check_field("inject", 32'(exp_status.inject), 32'(inject));
        check_field("event_word", exp_status.event_word, event_word);
        check_field("window_enable", 32'(exp_status.window_enable), 32'(window_enable));
        check_field("pending_valid", 32'(exp_status.pending_valid), 32'(pending_valid));
        check_field("highest_pending", 32'(exp_status.highest_pending),
                    32'(highest_pending));
        check_field("was_pending", 32'(exp_status.was_pending), 32'(was_pending));
        check_field("pending_total", 32'(exp_status.pending_total), 32'(pending_total));
      end
    end
    out_ready <= ready_pat[ready_pos];
    if (ready_pos == 4'd15) begin
      pat_rounds++;
      if (pat_rounds == 4) begin
        pat_rounds = 0;
        case ($urandom_range(0, 3))
          0:       ready_pat = 16'hffff;
          1:       ready_pat = 16'($urandom);
          2:       ready_pat = 16'($urandom) & 16'($urandom);
          default: ready_pat = 16'($urandom) | 16'($urandom);
        endcase
      end
    end
    ready_pos = ready_pos + 4'd1;
  end

  // Fill the request queue, release reset, then wait for the results to drain.
  initial begin
    // Attempts on an empty map, with and without a window request.
    req_q.push_back(mk(REQ_ATTEMPT, 8'h00, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    req_q.push_back(mk(REQ_ATTEMPT, 8'h00, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    // Lowest and highest vectors, then a duplicate raise.
    req_q.push_back(mk(REQ_RAISE, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    req_q.push_back(mk(REQ_RAISE, 8'hff, 32'hffff_ffff, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    req_q.push_back(mk(REQ_RAISE, 8'hff, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    // Re-inject: valid, bad type, valid bit clear, duplicate, all ones, valid 31.
    req_q.push_back(mk(REQ_REINJECT, 8'h00, 32'h8000_0080, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    req_q.push_back(mk(REQ_REINJECT, 8'h00, 32'h8000_0381, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    req_q.push_back(mk(REQ_REINJECT, 8'h00, 32'h7fff_f842, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    req_q.push_back(mk(REQ_REINJECT, 8'h00, 32'hffff_f880, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    req_q.push_back(mk(REQ_REINJECT, 8'hff, 32'hffff_ffff, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    req_q.push_back(mk(REQ_REINJECT, 8'h00, 32'h8000_001f, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    // Unused code must leave the map alone.
    req_q.push_back(mk(REQ_UNUSED, 8'hff, 32'hffff_ffff, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    // Each blocker on its own holds off injection.
    req_q.push_back(mk(REQ_ATTEMPT, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    req_q.push_back(mk(REQ_ATTEMPT, 8'h00, 32'h0000_0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    req_q.push_back(mk(REQ_ATTEMPT, 8'h00, 32'h0000_0000, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1));
    req_q.push_back(mk(REQ_ATTEMPT, 8'h00, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0));
    // Drain 255, 128, 31, 0 in priority order, last one closes the window.
    req_q.push_back(mk(REQ_ATTEMPT, 8'hff, 32'hffff_ffff, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    req_q.push_back(mk(REQ_ATTEMPT, 8'h00, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1));
    req_q.push_back(mk(REQ_ATTEMPT, 8'h00, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    req_q.push_back(mk(REQ_ATTEMPT, 8'h00, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    req_q.push_back(mk(REQ_ATTEMPT, 8'h00, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0));
    req_q.push_back(mk(REQ_RAISE, 8'h20, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));

    // Fill the whole map to reach a full count, poke duplicates, then drain it.
    for (int v = 0; v < 256; v++) begin
      req_q.push_back(mk(REQ_RAISE, 8'(v), 32'($urandom), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    end
    req_q.push_back(mk(REQ_RAISE, 8'h00, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    req_q.push_back(mk(REQ_REINJECT, 8'h00, 32'h8000_00ff, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    for (int k = 0; k < 260; k++) begin
      req_q.push_back(mk(REQ_ATTEMPT, 8'($urandom), 32'($urandom), 1'b1, 1'b0, 1'b0,
                         1'b0, 1'($urandom)));
    end

    // Random rounds: fill-heavy, drain-heavy and mixed.
    for (int rnd = 0; rnd < 13; rnd++) begin
      for (int k = 0; k < 100; k++) begin
        case (rnd % 3)
          0:       push_random(60, 20, 17);
          1:       push_random(10, 10, 77);
          default: push_random(30, 20, 47);
        endcase
      end
    end
    total_items = req_q.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (accepted_cnt < total_items || status_q.size() != 0) @(posedge clk);
    // Let any stray result show up before the verdict.
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
